/* sv/wtosc_pkg.sv */
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared constants, codes and types of the wavetable oscillator block.
// ----------------------------------------------------------------------------
package wtosc_pkg;

	localparam int TABLE_DEPTH  = 4096;
	localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
	localparam int SAMPLE_WIDTH = 16;
	localparam int PHASE_BITS   = 24;
	localparam int VALUE_WIDTH  = 16;
	localparam int MAX_LOG2     = TABLE_AW;

	// Fraction aligned to 23 bits, product scaling and rounding.
	localparam int FRAC_W       = PHASE_BITS - 1;
	localparam int SHIFT_BITS   = FRAC_W + 15;
	localparam int ACC_W        = VALUE_WIDTH + FRAC_W + 2;
	localparam int LO_W         = 20;
	localparam int HI_W         = ACC_W - LO_W;
	localparam int MUL_AW       = 25;
	localparam int MUL_BW       = 17;
	localparam int MUL_PW       = MUL_AW + MUL_BW;
	localparam int PL_W         = LO_W + 16;
	localparam int SUM_W        = 60;
	localparam int Q_W          = SUM_W - SHIFT_BITS;
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (SHIFT_BITS - 1);

	// Request codes.
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_WRITE   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_PHASE_STEP  = 2'd0,
		REG_AMPLITUDE   = 2'd1,
		REG_SIZE_LOG2   = 2'd2,
		REG_START_PHASE = 2'd3
	} reg_idx_t;

	localparam logic [23:0] RST_PHASE_STEP  = 24'd153791;
	localparam logic [15:0] RST_AMPLITUDE   = 16'd6554;
	localparam logic [3:0]  RST_SIZE_LOG2   = 4'd12;
	localparam logic [23:0] RST_START_PHASE = 24'd0;

	typedef struct packed {
		logic [23:0] phase_step;
		logic [15:0] amplitude;
		logic [3:0]  size_log2;
		logic [23:0] start_phase;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_MD,
		ST_ACC,
		ST_ML,
		ST_MH,
		ST_FIN
	} state_t;

endpackage

/* sv/wtosc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wtosc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/wtosc_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 25 by 17 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module wtosc_mul import wtosc_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic signed [MUL_PW-1:0] p
);

	logic signed [MUL_PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

/* sv/wtosc_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding increment, gain, table size and start phase.
// ----------------------------------------------------------------------------
module wtosc_cfg import wtosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	logic [23:0] phase_step_q;
	logic [15:0] amplitude_q;
	logic [3:0]  size_log2_q;
	logic [23:0] start_phase_q;
	reg_idx_t    idx;
	logic        wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= RST_PHASE_STEP;
			amplitude_q   <= RST_AMPLITUDE;
			size_log2_q   <= RST_SIZE_LOG2;
			start_phase_q <= RST_START_PHASE;
		end else if (wr_en) begin
			case (idx)
				REG_PHASE_STEP:  phase_step_q  <= pwdata[23:0];
				REG_AMPLITUDE:   amplitude_q   <= pwdata[15:0];
				REG_SIZE_LOG2:   size_log2_q   <= pwdata[3:0];
				REG_START_PHASE: start_phase_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PHASE_STEP:  prdata = {8'd0, phase_step_q};
			REG_AMPLITUDE:   prdata = {16'd0, amplitude_q};
			REG_SIZE_LOG2:   prdata = {28'd0, size_log2_q};
			REG_START_PHASE: prdata = {8'd0, start_phase_q};
			default:         prdata = 32'd0;
		endcase
	end

	// The datapath sees the table size clamped to the supported range.
	always_comb begin
		cfg.phase_step  = phase_step_q;
		cfg.amplitude   = amplitude_q;
		cfg.start_phase = start_phase_q;
		if (size_log2_q inside {[1:MAX_LOG2]}) begin
			cfg.size_log2 = size_log2_q;
		end else if (size_log2_q == 4'd0) begin
			cfg.size_log2 = 4'd1;
		end else begin
			cfg.size_log2 = 4'(MAX_LOG2);
		end
	end

endmodule

/* sv/wavetable_oscillator_linear_interp_unit.sv */
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// Phase accumulator oscillator that reads two neighboring table entries,
// blends them by the low phase bits, scales by a Q1.15 gain and emits one
// rounded, saturated sample per tick.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_type, table_index, table_value
// smp       out        smp_valid / smp_stall  sample
// config    in         APB, pready tied high  phase_step, amplitude,
//                                             table_size_log2, start_phase
//
// A tick beat runs two table reads through the single read port of the RAM,
// then three passes through the one shared multiplier and a final rounding
// add, before the next beat can be accepted.
// A table write or a phase restart beat gives no result.
// If the previous sample is still stalled at the output, the tick waits in
// its last step until the output register frees up.
// Reset clears the phase and the control state; the table is not cleared.
//
module wavetable_oscillator_linear_interp_unit import wtosc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Request channel.
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             req_type,
	input  logic [11:0]            table_index,
	input  logic signed [15:0]     table_value,
	// Sample channel.
	output logic                   smp_valid,
	input  logic                   smp_stall,
	output logic signed [15:0]     sample,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t                        cfg;
	state_t                      state_q, state_d;
	logic [PHASE_BITS-1:0]       phase_q;
	logic signed [VALUE_WIDTH-1:0] x1_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [PL_W-1:0]             pl_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                        smp_valid_q;

	logic                        req_acc;
	logic                        ram_we;
	logic [TABLE_AW-1:0]         ram_raddr;
	logic [VALUE_WIDTH-1:0]      ram_rdata;
	logic signed [MUL_AW-1:0]    mul_a;
	logic signed [MUL_BW-1:0]    mul_b;
	logic signed [MUL_PW-1:0]    mul_p;

	logic [TABLE_AW-1:0]         pos;
	logic [TABLE_AW-1:0]         nxt;
	logic [TABLE_AW-1:0]         size_mask;
	logic [PHASE_BITS-1:0]       frac_shifted;
	logic [FRAC_W-1:0]           frac_al;
	logic signed [MUL_BW-1:0]    diff;
	logic signed [ACC_W-1:0]     acc_d;
	logic signed [SUM_W-1:0]     ph_ext;
	logic [SUM_W-1:0]            sum;
	logic [Q_W-1:0]              q;
	logic                        ovf;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	logic                        out_free;
	logic                        fin_load;

	assign pready = 1'b1;

	wtosc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	wtosc_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (table_index[TABLE_AW-1:0]),
		.wdata (table_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wtosc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// The block takes a new beat only between ticks.
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign ram_we    = req_acc && (req_type == REQ_WRITE);

	// Table position is the top k phase bits; the neighbor wraps at the end
	// of the table in use.
	assign pos       = phase_q[PHASE_BITS-1 -: TABLE_AW] >> (4'(MAX_LOG2) - cfg.size_log2);
	assign size_mask = ~({TABLE_AW{1'b1}} << cfg.size_log2);
	assign nxt       = TABLE_AW'(pos + 1'b1) & size_mask;

	// The fraction below the position is left-aligned to FRAC_W bits, so all
	// table sizes share one fixed rounding point.
	assign frac_shifted = phase_q << (cfg.size_log2 - 4'd1);
	assign frac_al      = frac_shifted[FRAC_W-1:0];

	// Interpolation is x1 * 2^FRAC_W + (x2 - x1) * frac, with x2 arriving
	// straight from the RAM read register.
	assign diff  = {ram_rdata[VALUE_WIDTH-1], ram_rdata} - {x1_q[VALUE_WIDTH-1], x1_q};
	assign acc_d = {{(ACC_W-VALUE_WIDTH-FRAC_W){x1_q[VALUE_WIDTH-1]}}, x1_q, {FRAC_W{1'b0}}}
		+ mul_p[ACC_W-1:0];

	// Final gain product: high partial product shifted up plus the low one,
	// then round to nearest with ties upward and saturate.
	assign ph_ext = {{(SUM_W-MUL_PW){mul_p[MUL_PW-1]}}, mul_p};
	assign sum    = (ph_ext <<< LO_W) + {{(SUM_W-PL_W){1'b0}}, pl_q} + ROUND_BIAS;
	assign q      = sum[SUM_W-1:SHIFT_BITS];
	assign ovf    = (q[Q_W-1:SAMPLE_WIDTH-1] != {(Q_W-SAMPLE_WIDTH+1){q[Q_W-1]}});
	assign sat    = q[Q_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
		: {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

	assign out_free = !smp_valid_q || !smp_stall;
	assign fin_load = (state_q == ST_FIN) && out_free;

	// Sequencer: next state, RAM read address and multiplier operands.
	always_comb begin
		state_d   = state_q;
		ram_raddr = pos;
		mul_a     = {{(MUL_AW-HI_W){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:LO_W]};
		mul_b     = {1'b0, cfg.amplitude};
		case (state_q)
			ST_IDLE: begin
				if (req_acc && (req_type == REQ_TICK)) begin
					state_d = ST_RD1;
				end
			end
			ST_RD1: begin
				ram_raddr = pos;
				state_d   = ST_RD2;
			end
			ST_RD2: begin
				ram_raddr = nxt;
				state_d   = ST_MD;
			end
			ST_MD: begin
				mul_a   = {{(MUL_AW-FRAC_W){1'b0}}, frac_al};
				mul_b   = diff;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_ML;
			end
			ST_ML: begin
				mul_a   = {{(MUL_AW-LO_W){1'b0}}, acc_q[LO_W-1:0]};
				state_d = ST_MH;
			end
			ST_MH: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			smp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc && (req_type == REQ_RESTART)) begin
				phase_q <= cfg.start_phase;
			end else if (fin_load) begin
				phase_q <= phase_q + cfg.phase_step;
			end
			if (fin_load) begin
				smp_valid_q <= 1'b1;
			end else if (!smp_stall) begin
				smp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD2) begin
			x1_q <= ram_rdata;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_d;
		end
		if (state_q == ST_MH) begin
			pl_q <= mul_p[PL_W-1:0];
		end
		if (fin_load) begin
			sample_q <= ovf ? sat : q[SAMPLE_WIDTH-1:0];
		end
	end

	assign smp_valid = smp_valid_q;
	assign sample    = sample_q;

	// A new sample only appears out of the last step of a tick.
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(smp_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("sample valid rose outside the final tick step");

	// An accepted tick starts the table reads in the next cycle.
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req_type == REQ_TICK)) |=> state_q == ST_RD1)
		else $error("accepted tick did not start the sequencer");

	// The phase moves only on a restart or on a completed tick. The first
	// edge after reset is skipped, since the phase only just left reset.
	a_phase_moves: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && !$stable(phase_q)) |-> ($past(fin_load)
			|| $past(req_acc && (req_type == REQ_RESTART))))
		else $error("phase changed without a tick or restart");

	// A tick never completes while the previous sample is still stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid_q && smp_stall) |-> !fin_load)
		else $error("stalled sample would be overwritten");

endmodule
